// File: design/rrfs_pkg.sv
package rrfs_pkg;

    localparam int SLOT_COUNT = 4;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int MASK_W     = 4;
    localparam int ADDR_W     = 8;
    localparam int CODE_W     = 8;
    localparam int LEN_W      = 4;
    localparam int ID_W       = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] TICK_DIVIDE_RESET = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_TICK_DIVIDE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENT_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDR0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDR1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDR2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDR3   = 3'd5;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_POST = 1'b1;

    localparam logic [CODE_W-1:0] CODE_F3 = 8'hF3;
    localparam logic [CODE_W-1:0] CODE_F6 = 8'hF6;
    localparam logic [CODE_W-1:0] CODE_FD = 8'hFD;
    localparam logic [CODE_W-1:0] CODE_FE = 8'hFE;
    localparam logic [CODE_W-1:0] CODE_35 = 8'h35;
    localparam logic [CODE_W-1:0] CODE_36 = 8'h36;

    localparam logic [LEN_W-1:0] SECOND_FRAME_LEN = 4'd5;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scan;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic expire;
        logic scan_done;
        logic out_busy;
    } ctrl_status_t;

    function automatic logic [LEN_W-1:0] code_length(input logic [CODE_W-1:0] code);
        logic [LEN_W-1:0] len;
        case (code)
            CODE_F3: len = 4'd5;
            CODE_F6: len = 4'd7;
            CODE_FD: len = 4'd8;
            CODE_FE: len = 4'd4;
            CODE_35: len = 4'd2;
            CODE_36: len = 4'd2;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

endpackage

// File: design/rrfs_ctrl.sv
module rrfs_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  rrfs_pkg::ctrl_status_t status,
    output rrfs_pkg::ctrl_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = status.expire ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/rrfs_datapath.sv
module rrfs_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rrfs_pkg::ctrl_cmd_t                 cmd,
    output rrfs_pkg::ctrl_status_t              status,
    input  logic                                cfg_write_enable,
    input  logic [rrfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rrfs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_operation,
    input  logic [rrfs_pkg::SLOT_W-1:0]         s_target_slot,
    input  logic [rrfs_pkg::CODE_W-1:0]         s_command_code,
    input  logic                                s_has_second_frame,
    input  logic                                s_fifo_ready,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_frame_valid,
    output logic [rrfs_pkg::SLOT_W-1:0]         m_frame_slot,
    output logic [rrfs_pkg::ID_W-1:0]           m_frame_identifier,
    output logic                                m_frame_index,
    output logic [rrfs_pkg::LEN_W-1:0]          m_frame_length
);

    localparam int SW = rrfs_pkg::SLOT_W;
    localparam int SC = rrfs_pkg::SLOT_COUNT;

    // captured transaction
    logic                        in_op_reg;
    logic [SW-1:0]               in_slot_reg;
    logic [rrfs_pkg::CODE_W-1:0] in_code_reg;
    logic                        in_second_reg;
    logic                        in_fifo_reg;

    // configuration
    logic [7:0]                  tick_divide_reg;
    logic [rrfs_pkg::MASK_W-1:0] mask_reg;
    logic [rrfs_pkg::ADDR_W-1:0] node_addr_reg [rrfs_pkg::MASK_W];

    // scheduler state
    logic [7:0]                  prescale_reg;
    logic [7:0]                  prescale_next;
    logic [SW-1:0]               ptr_reg;
    logic [SW-1:0]               ptr_next;
    logic [SW-1:0]               k_reg;
    logic [SW-1:0]               k_next;
    logic [rrfs_pkg::CODE_W-1:0] code_reg  [SC];
    logic [rrfs_pkg::CODE_W-1:0] code_next [SC];
    logic [SC-1:0]               sfp_reg;
    logic [SC-1:0]               sfp_next;
    logic [SC-1:0]               ss_reg;
    logic [SC-1:0]               ss_next;

    // staged result
    logic                        res_valid_reg;
    logic [SW-1:0]               res_slot_reg;
    logic [rrfs_pkg::ID_W-1:0]   res_id_reg;
    logic                        res_idx_reg;
    logic [rrfs_pkg::LEN_W-1:0]  res_len_reg;

    logic [7:0]                  tick_count;
    logic [SW:0]                 slot_sum;
    logic [SW-1:0]               cur_slot;
    logic [SW-1:0]               cur_slot_inc;
    logic [rrfs_pkg::CODE_W-1:0] cur_code;
    logic                        cur_present;
    logic [rrfs_pkg::LEN_W-1:0]  base_len;
    logic                        serve;
    logic                        serve_idx;
    logic [rrfs_pkg::LEN_W-1:0]  serve_len;
    logic                        clr_ss;
    logic                        set_ss;
    logic                        clr_code;

    assign tick_count = prescale_reg + 8'd1;
    assign slot_sum   = {1'b0, ptr_reg} + {1'b0, k_reg};
    assign cur_slot   = (slot_sum >= (SW+1)'(SC)) ? SW'(slot_sum - (SW+1)'(SC))
                                                  : SW'(slot_sum);
    assign cur_slot_inc = (cur_slot == SW'(SC - 1)) ? '0 : cur_slot + SW'(1);
    assign cur_code     = code_reg[cur_slot];
    assign cur_present  = ({1'b0, cur_slot} < (SW+1)'(rrfs_pkg::MASK_W))
                          ? mask_reg[cur_slot] : 1'b0;
    assign base_len     = rrfs_pkg::code_length(cur_code);

    always_comb begin
        serve     = 1'b0;
        serve_idx = 1'b0;
        serve_len = '0;
        clr_ss    = 1'b0;
        set_ss    = 1'b0;
        clr_code  = 1'b0;
        if (!cur_present) begin
            clr_ss = 1'b1;
        end else if (ss_reg[cur_slot]) begin
            if (cur_code != rrfs_pkg::CODE_FD || !sfp_reg[cur_slot]) begin
                clr_ss = 1'b1;
            end else begin
                serve     = 1'b1;
                serve_idx = 1'b1;
                serve_len = rrfs_pkg::SECOND_FRAME_LEN;
                clr_ss    = in_fifo_reg;
                clr_code  = in_fifo_reg;
            end
        end else if (base_len != '0 &&
                     !(cur_code == rrfs_pkg::CODE_FD && !sfp_reg[cur_slot])) begin
            serve     = 1'b1;
            serve_len = base_len;
            if (cur_code == rrfs_pkg::CODE_FD) begin
                set_ss = in_fifo_reg;
            end else begin
                clr_code = in_fifo_reg;
            end
        end
    end

    assign status.expire    = (in_op_reg == rrfs_pkg::OP_TICK) &&
                              (tick_count == tick_divide_reg);
    assign status.scan_done = serve || (k_reg == SW'(SC - 1));
    assign status.out_busy  = m_valid && !m_ready;

    always_comb begin
        prescale_next = prescale_reg;
        ptr_next      = ptr_reg;
        k_next        = k_reg;
        code_next     = code_reg;
        sfp_next      = sfp_reg;
        ss_next       = ss_reg;
        if (cmd.exec) begin
            k_next = '0;
            if (in_op_reg == rrfs_pkg::OP_POST) begin
                if ({1'b0, in_slot_reg} < (SW+1)'(SC)) begin
                    code_next[in_slot_reg] = in_code_reg;
                    sfp_next[in_slot_reg]  = in_second_reg;
                end
            end else begin
                prescale_next = status.expire ? 8'd0 : tick_count;
            end
        end
        if (cmd.scan) begin
            k_next = k_reg + SW'(1);
            if (clr_ss) begin
                ss_next[cur_slot] = 1'b0;
            end
            if (set_ss) begin
                ss_next[cur_slot] = 1'b1;
            end
            if (clr_code) begin
                code_next[cur_slot] = '0;
            end
            if (serve) begin
                ptr_next = cur_slot_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_divide_reg <= rrfs_pkg::TICK_DIVIDE_RESET;
            mask_reg        <= '0;
            for (int i = 0; i < rrfs_pkg::MASK_W; i++) begin
                node_addr_reg[i] <= '0;
            end
        end else if (cfg_write_enable) begin
            case (cfg_index)
                rrfs_pkg::REG_TICK_DIVIDE:  tick_divide_reg  <= cfg_data;
                rrfs_pkg::REG_PRESENT_MASK: mask_reg         <= cfg_data[rrfs_pkg::MASK_W-1:0];
                rrfs_pkg::REG_NODE_ADDR0:   node_addr_reg[0] <= cfg_data;
                rrfs_pkg::REG_NODE_ADDR1:   node_addr_reg[1] <= cfg_data;
                rrfs_pkg::REG_NODE_ADDR2:   node_addr_reg[2] <= cfg_data;
                rrfs_pkg::REG_NODE_ADDR3:   node_addr_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_reg <= '0;
            ptr_reg      <= '0;
            k_reg        <= '0;
            sfp_reg      <= '0;
            ss_reg       <= '0;
            for (int i = 0; i < SC; i++) begin
                code_reg[i] <= '0;
            end
        end else begin
            prescale_reg <= prescale_next;
            ptr_reg      <= ptr_next;
            k_reg        <= k_next;
            sfp_reg      <= sfp_next;
            ss_reg       <= ss_next;
            code_reg     <= code_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_op_reg     <= s_operation;
            in_slot_reg   <= s_target_slot;
            in_code_reg   <= s_command_code;
            in_second_reg <= s_has_second_frame;
            in_fifo_reg   <= s_fifo_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_valid_reg <= 1'b0;
            res_slot_reg  <= '0;
            res_id_reg    <= '0;
            res_idx_reg   <= 1'b0;
            res_len_reg   <= '0;
        end else if (cmd.scan && serve && in_fifo_reg) begin
            res_valid_reg <= 1'b1;
            res_slot_reg  <= cur_slot;
            res_id_reg    <= {node_addr_reg[cur_slot], 7'd0, serve_idx};
            res_idx_reg   <= serve_idx;
            res_len_reg   <= serve_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_frame_valid      <= res_valid_reg;
            m_frame_slot       <= res_slot_reg;
            m_frame_identifier <= res_id_reg;
            m_frame_index      <= res_idx_reg;
            m_frame_length     <= res_len_reg;
        end
    end

endmodule

// File: design/round_robin_two_stage_frame_scheduler_unit.sv
// Round-robin frame scheduler for four slots.
// Input channel (s_*): each transaction is either a post, which stores a
// command code and second-frame flag for s_target_slot, or a tick, which
// advances the prescaler. When the prescaler reaches tick_divide a round
// runs: slots are examined one per cycle from the rotating pointer, and the
// first eligible slot yields one frame descriptor if s_fifo_ready is high.
// Result channel (m_*): exactly one transaction per input transaction;
// m_frame_valid is zero (all fields zero) for posts, non-expiring ticks,
// refused frames and rounds with no eligible slot.
// Sequence: accept, an execute step, on an expiring tick a scan of one to
// four slots, then loading of the output register; a post or plain tick
// skips the scan. One transaction is in work at a time; the scan over the
// slots sets the round length.
// The output register holds a result while m_ready is low; the next input
// transaction is accepted meanwhile and its result waits until it frees.
// Reset (aresetn low, synchronous) clears all pending codes, stage flags,
// the pointer and prescaler, and sets tick_divide to 10, mask and node addresses to 0.
// Configuration is written through cfg_write_enable/cfg_index/cfg_data.
module round_robin_two_stage_frame_scheduler_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_write_enable,
    input  logic [rrfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rrfs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic [rrfs_pkg::SLOT_W-1:0]         s_target_slot,
    input  logic [rrfs_pkg::CODE_W-1:0]         s_command_code,
    input  logic                                s_has_second_frame,
    input  logic                                s_fifo_ready,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_frame_valid,
    output logic [rrfs_pkg::SLOT_W-1:0]         m_frame_slot,
    output logic [rrfs_pkg::ID_W-1:0]           m_frame_identifier,
    output logic                                m_frame_index,
    output logic [rrfs_pkg::LEN_W-1:0]          m_frame_length
);

    rrfs_pkg::ctrl_cmd_t    cmd;
    rrfs_pkg::ctrl_status_t status;

    rrfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rrfs_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .cfg_write_enable   (cfg_write_enable),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_operation        (s_operation),
        .s_target_slot      (s_target_slot),
        .s_command_code     (s_command_code),
        .s_has_second_frame (s_has_second_frame),
        .s_fifo_ready       (s_fifo_ready),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_frame_valid      (m_frame_valid),
        .m_frame_slot       (m_frame_slot),
        .m_frame_identifier (m_frame_identifier),
        .m_frame_index      (m_frame_index),
        .m_frame_length     (m_frame_length)
    );

    // one transaction in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a transaction is in work");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_valid |-> m_frame_length == '0 && m_frame_identifier == '0)
        else $error("empty result carries nonzero fields");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_valid |-> m_frame_identifier[0] == m_frame_index &&
                                     m_frame_length != '0)
        else $error("frame descriptor inconsistent");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_valid && m_frame_index |-> m_frame_length == rrfs_pkg::SECOND_FRAME_LEN)
        else $error("second frame with wrong length");

endmodule

// File: tb/sv/tb_round_robin_two_stage_frame_scheduler_unit.sv
module tb_round_robin_two_stage_frame_scheduler_unit;

    localparam int CYCLE_LIMIT = 400000;

    localparam int SW = rrfs_pkg::SLOT_W;
    localparam int CW = rrfs_pkg::CODE_W;
    localparam int LW = rrfs_pkg::LEN_W;
    localparam int IW = rrfs_pkg::ID_W;
    localparam int MW = rrfs_pkg::MASK_W;
    localparam int AW = rrfs_pkg::ADDR_W;
    localparam int SC = rrfs_pkg::SLOT_COUNT;

    typedef struct packed {
        logic          valid;
        logic [SW-1:0] slot;
        logic [IW-1:0] ident;
        logic          index;
        logic [LW-1:0] frame_len;
    } frame_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_write_enable = 1'b0;
    logic [rrfs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rrfs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic                            s_operation = rrfs_pkg::OP_TICK;
    logic [SW-1:0]                   s_target_slot = '0;
    logic [CW-1:0]                   s_command_code = '0;
    logic                            s_has_second_frame = 1'b0;
    logic                            s_fifo_ready = 1'b0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic                            m_frame_valid;
    logic [SW-1:0]                   m_frame_slot;
    logic [IW-1:0]                   m_frame_identifier;
    logic                            m_frame_index;
    logic [LW-1:0]                   m_frame_length;

    round_robin_two_stage_frame_scheduler_unit dut (.*);

    // scheduler mirror
    logic [7:0]    tick_div = rrfs_pkg::TICK_DIVIDE_RESET;
    logic [MW-1:0] present_mask = '0;
    logic [AW-1:0] node_addr [SC];
    logic [7:0]    prescale = '0;
    logic [SW-1:0] rr_ptr = '0;
    logic [CW-1:0] pend_code [SC];
    logic          second_buf [SC];
    logic          stage_two [SC];

    frame_t frame_expect_q[$];
    int     gap_pct = 0;
    int     stall_pct = 0;
    int     error_count = 0;
    int     items_sent = 0;
    int     frames_seen = 0;
    int     idle_seen = 0;
    int     cycle_count = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch %s: got 0x%0h expected 0x%0h (t=%0t)", what, got, want, $time);
    endtask

    always @(posedge aclk) begin
        frame_t want;
        if (aresetn && m_valid && m_ready) begin
            if (frame_expect_q.size() == 0) begin
                report_mismatch("unexpected transaction", 32'(m_frame_valid), 32'd0);
            end else begin
                want = frame_expect_q.pop_front();
                if (m_frame_valid !== want.valid)
                    report_mismatch("frame_valid", 32'(m_frame_valid), 32'(want.valid));
                if (m_frame_slot !== want.slot)
                    report_mismatch("frame_slot", 32'(m_frame_slot), 32'(want.slot));
                if (m_frame_identifier !== want.ident)
                    report_mismatch("frame_identifier", 32'(m_frame_identifier),
                                    32'(want.ident));
                if (m_frame_index !== want.index)
                    report_mismatch("frame_index", 32'(m_frame_index), 32'(want.index));
                if (m_frame_length !== want.frame_len)
                    report_mismatch("frame_length", 32'(m_frame_length),
                                    32'(want.frame_len));
                if (want.valid)
                    frames_seen++;
                else
                    idle_seen++;
            end
        end
    end

    function automatic logic [LW-1:0] frame_bytes(input logic [CW-1:0] code);
        case (code)
            rrfs_pkg::CODE_F3: return 4'd5;
            rrfs_pkg::CODE_F6: return 4'd7;
            rrfs_pkg::CODE_FD: return 4'd8;
            rrfs_pkg::CODE_FE: return 4'd4;
            rrfs_pkg::CODE_35, rrfs_pkg::CODE_36: return 4'd2;
            default: return 4'd0;
        endcase
    endfunction

    function automatic frame_t predict_frame(input logic op, input logic [SW-1:0] tslot,
                                             input logic [CW-1:0] code, input logic sec,
                                             input logic rdy);
        frame_t        r;
        int            k;
        int            s;
        logic          served;
        logic          ok;
        logic          idx;
        logic [LW-1:0] len;
        r = '0;
        served = 1'b0;
        if (op == rrfs_pkg::OP_POST) begin
            pend_code[tslot] = code;
            second_buf[tslot] = sec;
            return r;
        end
        prescale = prescale + 8'd1;
        if (prescale != tick_div)
            return r;
        prescale = '0;
        for (k = 0; k < SC; k++) begin
            if (!served) begin
                s = (int'(rr_ptr) + k) % SC;
                ok = 1'b0;
                idx = 1'b0;
                len = '0;
                if (!present_mask[s]) begin
                    stage_two[s] = 1'b0;
                end else if (stage_two[s]) begin
                    if (pend_code[s] != rrfs_pkg::CODE_FD || !second_buf[s]) begin
                        stage_two[s] = 1'b0;
                    end else begin
                        ok = 1'b1;
                        idx = 1'b1;
                        len = rrfs_pkg::SECOND_FRAME_LEN;
                        if (rdy) begin
                            stage_two[s] = 1'b0;
                            pend_code[s] = '0;
                        end
                    end
                end else begin
                    len = frame_bytes(pend_code[s]);
                    if (len != '0 &&
                        !(pend_code[s] == rrfs_pkg::CODE_FD && !second_buf[s])) begin
                        ok = 1'b1;
                        if (rdy) begin
                            if (pend_code[s] == rrfs_pkg::CODE_FD)
                                stage_two[s] = 1'b1;
                            else
                                pend_code[s] = '0;
                        end
                    end
                end
                if (ok) begin
                    served = 1'b1;
                    rr_ptr = SW'((s + 1) % SC);
                    if (rdy) begin
                        r.valid = 1'b1;
                        r.slot = SW'(s);
                        r.ident = {node_addr[s], 7'b0, idx};
                        r.index = idx;
                        r.frame_len = len;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic send_item(input logic op, input logic [SW-1:0] slot,
                             input logic [CW-1:0] code, input logic sec, input logic rdy);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_target_slot <= slot;
        s_command_code <= code;
        s_has_second_frame <= sec;
        s_fifo_ready <= rdy;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        frame_expect_q.push_back(predict_frame(op, slot, code, sec, rdy));
        items_sent++;
    endtask

    task automatic post(input logic [SW-1:0] slot, input logic [CW-1:0] code,
                        input logic sec);
        send_item(rrfs_pkg::OP_POST, slot, code, sec, 1'($urandom_range(1)));
    endtask

    task automatic tick(input logic rdy);
        send_item(rrfs_pkg::OP_TICK, SW'($urandom_range(3)), CW'($urandom_range(255)),
                  1'($urandom_range(1)), rdy);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (frame_expect_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [rrfs_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_write_enable <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        case (idx)
            rrfs_pkg::REG_TICK_DIVIDE:  tick_div = data;
            rrfs_pkg::REG_PRESENT_MASK: present_mask = data[MW-1:0];
            rrfs_pkg::REG_NODE_ADDR0:   node_addr[0] = data;
            rrfs_pkg::REG_NODE_ADDR1:   node_addr[1] = data;
            rrfs_pkg::REG_NODE_ADDR2:   node_addr[2] = data;
            rrfs_pkg::REG_NODE_ADDR3:   node_addr[3] = data;
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [7:0] td, input logic [MW-1:0] mask,
                               input logic [7:0] a0, input logic [7:0] a1,
                               input logic [7:0] a2, input logic [7:0] a3);
        wait_idle();
        write_reg(rrfs_pkg::REG_TICK_DIVIDE, td);
        write_reg(rrfs_pkg::REG_PRESENT_MASK, {4'b0, mask});
        write_reg(rrfs_pkg::REG_NODE_ADDR0, a0);
        write_reg(rrfs_pkg::REG_NODE_ADDR1, a1);
        write_reg(rrfs_pkg::REG_NODE_ADDR2, a2);
        write_reg(rrfs_pkg::REG_NODE_ADDR3, a3);
        cfg_write_enable <= 1'b0;
    endtask

    function automatic logic [CW-1:0] pick_known(input int sel);
        case (sel)
            0: return rrfs_pkg::CODE_F3;
            1: return rrfs_pkg::CODE_F6;
            2: return rrfs_pkg::CODE_FD;
            3: return rrfs_pkg::CODE_FE;
            4: return rrfs_pkg::CODE_35;
            default: return rrfs_pkg::CODE_36;
        endcase
    endfunction

    // mostly valid codes, some garbage; runs until tick_total ticks went in
    task automatic random_traffic(input int tick_total, input int post_pct);
        int            ticks;
        int            r;
        logic [CW-1:0] code;
        ticks = 0;
        while (ticks < tick_total) begin
            r = int'($urandom_range(99));
            if (r < post_pct * 3 / 4) begin
                code = pick_known(int'($urandom_range(5)));
                post(SW'($urandom_range(3)), code,
                     (code == rrfs_pkg::CODE_FD) ? ($urandom_range(7) != 0)
                                                 : 1'($urandom_range(1)));
            end else if (r < post_pct) begin
                post(SW'($urandom_range(3)), CW'($urandom_range(255)), 1'($urandom_range(1)));
            end else begin
                tick($urandom_range(3) != 0);
                ticks++;
            end
        end
    endtask

    task automatic test_reset_defaults();
        post(2'd0, rrfs_pkg::CODE_F3, 1'b0);
        post(2'd3, rrfs_pkg::CODE_FD, 1'b1);
        repeat (12) tick(1'b1);
    endtask

    task automatic test_frame_codes();
        load_config(8'd1, 4'hF, 8'h00, 8'hFF, 8'h5A, 8'hA5);
        post(2'd0, rrfs_pkg::CODE_F3, 1'b0);
        post(2'd1, rrfs_pkg::CODE_F6, 1'b1);
        post(2'd2, rrfs_pkg::CODE_FD, 1'b1);
        post(2'd3, rrfs_pkg::CODE_FE, 1'b0);
        tick(1'b1);
        tick(1'b0);
        tick(1'b1);
        tick(1'b1);
        tick(1'b1);
        tick(1'b1);
        tick(1'b1);
        post(2'd0, rrfs_pkg::CODE_35, 1'b0);
        post(2'd1, rrfs_pkg::CODE_36, 1'b0);
        post(2'd2, rrfs_pkg::CODE_FD, 1'b0);
        post(2'd3, 8'h00, 1'b1);
        repeat (3) tick(1'b1);
        post(2'd3, 8'hFF, 1'b1);
        post(2'd2, rrfs_pkg::CODE_FD, 1'b1);
        tick(1'b1);
        // break the second stage by overwriting the code
        post(2'd2, rrfs_pkg::CODE_F3, 1'b1);
        repeat (3) tick(1'b1);
    endtask

    task automatic test_slot_presence();
        load_config(8'd1, 4'hF, 8'h12, 8'h34, 8'h56, 8'h78);
        post(2'd0, 8'h00, 1'b0);
        post(2'd1, rrfs_pkg::CODE_FD, 1'b1);
        post(2'd2, 8'h00, 1'b0);
        post(2'd3, 8'h00, 1'b0);
        tick(1'b1);
        // slot 1 leaves while in the second stage
        load_config(8'd1, 4'b1101, 8'h12, 8'h34, 8'h56, 8'h78);
        tick(1'b1);
        load_config(8'd2, 4'hF, 8'h12, 8'h34, 8'h56, 8'h78);
        repeat (6) tick(1'b1);
        load_config(8'd2, 4'b0101, 8'hFF, 8'h00, 8'hFF, 8'h00);
        post(2'd0, rrfs_pkg::CODE_F6, 1'b0);
        post(2'd1, rrfs_pkg::CODE_F3, 1'b0);
        post(2'd2, rrfs_pkg::CODE_FE, 1'b0);
        post(2'd3, rrfs_pkg::CODE_36, 1'b0);
        repeat (8) tick(1'b1);
    endtask

    task automatic test_prescaler_extremes();
        gap_pct = 22;
        stall_pct = 22;
        load_config(8'd255, 4'hF, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)));
        random_traffic(256, 8);
        // divide of zero sits below the count, fires only on wrap
        load_config(8'd0, 4'hF, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)));
        random_traffic(256, 8);
    endtask

    task automatic test_random_phase(input int gap, input int stall, input logic [7:0] td,
                                     input logic [MW-1:0] mask);
        load_config(td, mask, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)));
        gap_pct = gap;
        stall_pct = stall;
        random_traffic(150, 40);
    endtask

    initial begin
        int i;
        for (i = 0; i < SC; i++) begin
            node_addr[i] = '0;
            pend_code[i] = '0;
            second_buf[i] = 1'b0;
            stage_two[i] = 1'b0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_frame_codes();
        test_slot_presence();
        test_prescaler_extremes();
        test_random_phase(0, 0, 8'd1, 4'hF);
        test_random_phase(54, 0, 8'd2, MW'($urandom_range(15)));
        test_random_phase(0, 54, 8'd3, 4'b1010);
        test_random_phase(22, 22, 8'd1, 4'b0111);
        gap_pct = 0;
        stall_pct = 0;
        wait_idle();

        $display("run covered %0d transactions: %0d frames sent, %0d empty results",
                 items_sent, frames_seen, idle_seen);
        $display("codes, second stage, absent slots, busy FIFO, divides 0..255, four idle mixes");
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
